FILE: rtl/limit_order_book_matcher_unit_assert.svh
// Assertion macros for the bound checker module.
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LOBM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LOBM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lobm_pkg.sv
package lobm_pkg;

	localparam int MAX_ORDERS_DEF = 32;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_CANCEL,
		OP_MATCH,
		OP_CLEAR,
		OP_QUERY,
		OP_NOP
	} op_t;

	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_CANCEL = 3'd1;
	localparam logic [2:0] MODE_MATCH  = 3'd2;
	localparam logic [2:0] MODE_CLEAR  = 3'd3;
	localparam logic [2:0] MODE_QUERY  = 3'd4;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NOTFOUND = 2'd1;
	localparam logic [1:0] STS_FULL     = 2'd2;
	localparam logic [1:0] STS_DUP      = 2'd3;

	localparam logic SIDE_BUY = 1'b0;

	localparam logic KIND_TRADE = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_TRADE,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] oid;
		logic        side;
		logic [15:0] price;
		logic [23:0] quantity;
		logic [47:0] timestamp;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] maker_id;
		logic [31:0] taker_id;
		logic [15:0] trade_price;
		logic [23:0] trade_qty;
		logic [47:0] trade_time;
		logic        aggressor_side;
		logic [15:0] bid_px;
		logic [15:0] ask_px;
		logic [38:0] level_quantity;
		logic [1:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] id;
		logic        side;
		logic [15:0] price;
		logic [23:0] qty;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

FILE: rtl/lobm_ram.sv
module lobm_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/lobm_front.sv
module lobm_front import lobm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [31:0] oid,
	input  logic        side,
	input  logic [15:0] price,
	input  logic [23:0] quantity,
	input  logic [47:0] timestamp,
	input  logic        busy,
	output logic        valid,
	input  logic        take,
	output item_t       item
);

	item_t      buf_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       acc, deq;

	always_comb begin
		cls.oid       = oid;
		cls.side      = side;
		cls.price     = price;
		cls.quantity  = quantity;
		cls.timestamp = timestamp;
		case (mode)
			MODE_ADD:    cls.op = OP_ADD;
			MODE_CANCEL: cls.op = OP_CANCEL;
			MODE_MATCH:  cls.op = OP_MATCH;
			MODE_CLEAR:  cls.op = OP_CLEAR;
			MODE_QUERY:  cls.op = OP_QUERY;
			default:     cls.op = OP_NOP;
		endcase
	end

	assign full  = (cnt_q == 2'd2) || busy;
	assign valid = (cnt_q != 2'd0);
	assign item  = buf_q[rptr_q];
	assign acc   = push && !full;
	assign deq   = take && valid;

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (acc) wptr_q <= !wptr_q;
			if (deq) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, deq};
		end
	end

endmodule

FILE: rtl/lobm_resq.sv
module lobm_resq import lobm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  result_t din,
	output logic    afull,
	input  logic    pop,
	output logic    empty,
	output result_t dout
);

	result_t    buf_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       acc, deq;

	assign afull = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = buf_q[rptr_q];
	assign acc   = wr && !afull;
	assign deq   = pop && !empty;

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (acc) wptr_q <= !wptr_q;
			if (deq) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, deq};
		end
	end

endmodule

FILE: rtl/lobm_engine.sv
module lobm_engine import lobm_pkg::*; #(
	parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  item_t   in_item,
	output logic    in_take,
	output logic    busy,
	output logic    res_wr,
	output result_t res_data,
	input  logic    res_full
);

	localparam int AW = $clog2(MAX_ORDERS);
	localparam int CW = $clog2(MAX_ORDERS + 1);
	localparam logic [CW-1:0] N_C    = CW'(MAX_ORDERS);
	localparam logic [CW-1:0] LAST_C = CW'(MAX_ORDERS - 1);

	state_t        state_q, state_d;
	item_t         cur_q;
	logic [CW-1:0] cnt_q;
	logic          rd_s1;
	logic [AW-1:0] idx_s1;
	logic          fin_q;
	logic [23:0]   rem_q;
	logic [CW-1:0] n_q;
	logic [1:0]    status_q;

	logic          fnd_q, free_ok_q, bst_ok_q, have_ask_q;
	logic [AW-1:0] fnd_idx_q, free_idx_q, bst_idx_q;
	logic [31:0]   bst_id_q;
	logic [15:0]   bst_price_q, bid_q, ask_q;
	logic [23:0]   bst_qty_q;
	logic [38:0]   lvl_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	slot_t         ram_wdata, rd;
	logic [SLOT_W-1:0] rdata;

	logic          start_scan, start_clear, ld_item, do_fill, set_fin;
	logic          set_status;
	logic [1:0]    status_d;
	logic [23:0]   fill;
	logic [23:0]   left;
	logic          cand, better;

	lobm_ram #(.W(SLOT_W), .D(MAX_ORDERS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q[AW-1:0]),
		.rdata(rdata)
	);

	assign rd   = slot_t'(rdata);
	assign busy = (state_q == ST_INIT);
	assign fill = (rem_q < bst_qty_q) ? rem_q : bst_qty_q;
	assign left = bst_qty_q - fill;

	always_comb begin
		cand = rd.valid && (rd.side != cur_q.side) &&
			((cur_q.side == SIDE_BUY) ? (rd.price <= cur_q.price) : (rd.price >= cur_q.price));
		if (!bst_ok_q) begin
			better = 1'b1;
		end else if (rd.price != bst_price_q) begin
			better = (cur_q.side == SIDE_BUY) ? (rd.price < bst_price_q) : (rd.price > bst_price_q);
		end else begin
			better = rd.id < bst_id_q;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_take     = 1'b0;
		start_scan  = 1'b0;
		start_clear = 1'b0;
		ld_item     = 1'b0;
		do_fill     = 1'b0;
		set_fin     = 1'b0;
		set_status  = 1'b0;
		status_d    = STS_OK;
		ram_we      = 1'b0;
		ram_waddr   = cnt_q[AW-1:0];
		ram_wdata   = '0;
		res_wr      = 1'b0;
		res_data    = '0;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				ram_we = 1'b1;
				if (cnt_q == LAST_C) begin
					if (state_q == ST_INIT) begin
						state_d = ST_IDLE;
					end else begin
						state_d    = ST_SCAN;
						start_scan = 1'b1;
						set_fin    = 1'b1;
					end
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					in_take    = 1'b1;
					ld_item    = 1'b1;
					start_scan = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == N_C) state_d = ST_ACT;
			end
			ST_ACT: begin
				state_d    = ST_SCAN;
				start_scan = 1'b1;
				set_fin    = 1'b1;
				if (fin_q) begin
					state_d    = ST_DONE;
					start_scan = 1'b0;
					set_fin    = 1'b0;
				end else begin
					case (cur_q.op)
						OP_ADD: begin
							if (cur_q.price != '0 && cur_q.quantity != '0) begin
								if (fnd_q) begin
									set_status = 1'b1;
									status_d   = STS_DUP;
								end else if (!free_ok_q) begin
									set_status = 1'b1;
									status_d   = STS_FULL;
								end else begin
									ram_we    = 1'b1;
									ram_waddr = free_idx_q;
									ram_wdata = '{1'b1, cur_q.oid, cur_q.side,
										cur_q.price, cur_q.quantity};
								end
							end
						end
						OP_CANCEL: begin
							if (fnd_q) begin
								ram_we    = 1'b1;
								ram_waddr = fnd_idx_q;
							end else begin
								set_status = 1'b1;
								status_d   = STS_NOTFOUND;
							end
						end
						OP_MATCH: begin
							if (cur_q.price == '0) begin
								// nothing to do
							end else if (fnd_q) begin
								set_status = 1'b1;
								status_d   = STS_DUP;
							end else if (rem_q != '0 && n_q < N_C && bst_ok_q) begin
								state_d    = ST_TRADE;
								start_scan = 1'b0;
								set_fin    = 1'b0;
							end else if (rem_q != '0) begin
								if (free_ok_q) begin
									ram_we    = 1'b1;
									ram_waddr = free_idx_q;
									ram_wdata = '{1'b1, cur_q.oid, cur_q.side,
										cur_q.price, rem_q};
								end else begin
									set_status = 1'b1;
									status_d   = STS_FULL;
								end
							end
						end
						OP_CLEAR: begin
							state_d     = ST_CLEAR;
							start_scan  = 1'b0;
							set_fin     = 1'b0;
							start_clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_TRADE: begin
				if (!res_full) begin
					res_wr                  = 1'b1;
					res_data.kind           = KIND_TRADE;
					res_data.maker_id       = bst_id_q;
					res_data.taker_id       = cur_q.oid;
					res_data.trade_price    = bst_price_q;
					res_data.trade_qty      = fill;
					res_data.trade_time     = cur_q.timestamp;
					res_data.aggressor_side = cur_q.side;
					ram_we    = 1'b1;
					ram_waddr = bst_idx_q;
					ram_wdata = '{left != '0, bst_id_q, !cur_q.side, bst_price_q, left};
					do_fill    = 1'b1;
					start_scan = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_DONE: begin
				if (!res_full) begin
					res_wr            = 1'b1;
					res_data.kind     = KIND_DONE;
					res_data.bid_px   = bid_q;
					res_data.ask_px   = have_ask_q ? ask_q : '0;
					res_data.level_quantity = (cur_q.op == OP_QUERY) ? lvl_q : '0;
					res_data.status   = status_q;
					res_data.last     = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cnt_q      <= '0;
			rd_s1      <= 1'b0;
			fin_q      <= 1'b0;
			status_q   <= STS_OK;
			n_q        <= '0;
			rem_q      <= '0;
			fnd_q      <= 1'b0;
			free_ok_q  <= 1'b0;
			bst_ok_q   <= 1'b0;
			have_ask_q <= 1'b0;
			bid_q      <= '0;
			lvl_q      <= '0;
		end else begin
			state_q <= state_d;
			rd_s1   <= (state_q == ST_SCAN) && (cnt_q < N_C);
			if (start_scan || start_clear) begin
				cnt_q <= '0;
			end else if (state_q == ST_SCAN || state_q == ST_INIT || state_q == ST_CLEAR) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ld_item) begin
				fin_q    <= 1'b0;
				status_q <= STS_OK;
				n_q      <= '0;
				rem_q    <= in_item.quantity;
			end
			if (set_fin) fin_q <= 1'b1;
			if (set_status) status_q <= status_d;
			if (do_fill) begin
				rem_q <= rem_q - fill;
				n_q   <= n_q + 1'b1;
			end
			if (start_scan) begin
				fnd_q      <= 1'b0;
				free_ok_q  <= 1'b0;
				bst_ok_q   <= 1'b0;
				have_ask_q <= 1'b0;
				bid_q      <= '0;
				lvl_q      <= '0;
			end else if (rd_s1) begin
				if (rd.valid && rd.id == cur_q.oid) fnd_q <= 1'b1;
				if (!rd.valid && !free_ok_q) free_ok_q <= 1'b1;
				if (rd.valid && rd.side == cur_q.side && rd.price == cur_q.price) begin
					lvl_q <= lvl_q + 39'(rd.qty);
				end
				if (rd.valid && rd.side == SIDE_BUY && rd.price > bid_q) bid_q <= rd.price;
				if (rd.valid && rd.side != SIDE_BUY && (!have_ask_q || rd.price < ask_q)) begin
					have_ask_q <= 1'b1;
				end
				if (cand && better) bst_ok_q <= 1'b1;
			end
		end
	end

	// datapath side of the scan, no reset needed
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		if (ld_item) cur_q <= in_item;
		if (!start_scan && rd_s1) begin
			if (rd.valid && rd.id == cur_q.oid) fnd_idx_q <= idx_s1;
			if (!rd.valid && !free_ok_q) free_idx_q <= idx_s1;
			if (rd.valid && rd.side != SIDE_BUY && (!have_ask_q || rd.price < ask_q)) begin
				ask_q <= rd.price;
			end
			if (cand && better) begin
				bst_idx_q   <= idx_s1;
				bst_id_q    <= rd.id;
				bst_price_q <= rd.price;
				bst_qty_q   <= rd.qty;
			end
		end
	end

endmodule

FILE: rtl/limit_order_book_matcher_unit.sv
// Price/order-id priority limit order book with a table of MAX_ORDERS slots.
// Input channel: drive push with mode, oid, side, price, quantity and
// timestamp; the item is taken on a clock edge with push high and full low.
// Result channel: while empty is low the oldest record sits on the result
// ports; pop on a clock edge with empty low takes it. Each input yields zero
// or more trade records (kind 0) followed by one completion record (kind 1,
// last 1) carrying best bid, best ask, status and, for a query, level lots.
// Every table access walks the slot memory one slot per cycle through its
// single read port. A plain input takes two passes; a match adds one pass
// per fill; a clear adds a wipe of the table. Items are processed one at a
// time; a two-entry input queue and a two-entry result queue decouple both
// sides. After reset the block wipes the table with full held high.
// When pop stays low the result queue fills, the engine holds its current
// record and full rises once the input queue is also full; nothing is
// dropped.
module limit_order_book_matcher_unit import lobm_pkg::*; #(
	parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [31:0] oid,
	input  logic        side,
	input  logic [15:0] price,
	input  logic [23:0] quantity,
	input  logic [47:0] timestamp,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [31:0] maker_id,
	output logic [31:0] taker_id,
	output logic [15:0] trade_price,
	output logic [23:0] trade_qty,
	output logic [47:0] trade_time,
	output logic        aggressor_side,
	output logic [15:0] bid_px,
	output logic [15:0] ask_px,
	output logic [38:0] level_quantity,
	output logic [1:0]  status,
	output logic        last
);

	item_t   item;
	logic    item_valid, item_take, busy;
	logic    res_wr, res_full;
	result_t res_in, res_out;

	lobm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.mode     (mode),
		.oid      (oid),
		.side     (side),
		.price    (price),
		.quantity (quantity),
		.timestamp(timestamp),
		.busy     (busy),
		.valid    (item_valid),
		.take     (item_take),
		.item     (item)
	);

	lobm_engine #(.MAX_ORDERS(MAX_ORDERS)) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item_valid),
		.in_item (item),
		.in_take (item_take),
		.busy    (busy),
		.res_wr  (res_wr),
		.res_data(res_in),
		.res_full(res_full)
	);

	lobm_resq u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_wr),
		.din   (res_in),
		.afull (res_full),
		.pop   (pop),
		.empty (empty),
		.dout  (res_out)
	);

	assign kind           = res_out.kind;
	assign maker_id       = res_out.maker_id;
	assign taker_id       = res_out.taker_id;
	assign trade_price    = res_out.trade_price;
	assign trade_qty      = res_out.trade_qty;
	assign trade_time     = res_out.trade_time;
	assign aggressor_side = res_out.aggressor_side;
	assign bid_px         = res_out.bid_px;
	assign ask_px         = res_out.ask_px;
	assign level_quantity = res_out.level_quantity;
	assign status         = res_out.status;
	assign last           = res_out.last;

endmodule

FILE: rtl/lobm_checker.sv
`include "limit_order_book_matcher_unit_assert.svh"

module lobm_checker import lobm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [31:0] maker_id,
	input logic [23:0] trade_qty,
	input logic [15:0] bid_px,
	input logic [15:0] ask_px,
	input logic [1:0]  status,
	input logic        last
);

	// completion and last always travel together
	`LOBM_ASSERT_NOW(a_last_kind, clk, arst_n, !empty, kind == last, "last differs from kind")
	// trade records carry no book summary
	`LOBM_ASSERT_NOW(a_trade_clean, clk, arst_n, !empty && kind == KIND_TRADE, status == STS_OK && bid_px == '0 && ask_px == '0, "trade record has summary fields")
	// completion records carry no fill
	`LOBM_ASSERT_NOW(a_done_clean, clk, arst_n, !empty && kind == KIND_DONE, trade_qty == '0 && maker_id == '0, "completion record has fill fields")
	// hold a stalled record
	`LOBM_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(kind) && $stable(maker_id) && $stable(trade_qty), "stalled record changed")

endmodule

bind limit_order_book_matcher_unit lobm_checker u_lobm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.kind     (kind),
	.maker_id (maker_id),
	.trade_qty(trade_qty),
	.bid_px   (bid_px),
	.ask_px   (ask_px),
	.status   (status),
	.last     (last)
);

FILE: tb/sv/limit_order_book_matcher_unit_checker.sv
`timescale 1ns / 100ps

module limit_order_book_matcher_unit_checker import lobm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [2:0]  mode,
	input  logic [31:0] oid,
	input  logic        side,
	input  logic [15:0] price,
	input  logic [23:0] quantity,
	input  logic [47:0] timestamp,
	input  logic        empty,
	input  logic        pop,
	input  logic        kind,
	input  logic [31:0] maker_id,
	input  logic [31:0] taker_id,
	input  logic [15:0] trade_price,
	input  logic [23:0] trade_qty,
	input  logic [47:0] trade_time,
	input  logic        aggressor_side,
	input  logic [15:0] bid_px,
	input  logic [15:0] ask_px,
	input  logic [38:0] level_quantity,
	input  logic [1:0]  status,
	input  logic        last,
	output int          errors,
	output int          pending
);

	localparam int DEPTH = MAX_ORDERS_DEF;

	logic        book_live  [DEPTH];
	logic [31:0] book_id    [DEPTH];
	logic        book_side  [DEPTH];
	logic [15:0] book_price [DEPTH];
	logic [23:0] book_qty   [DEPTH];

	result_t expected_records[$];

	assign pending = expected_records.size();

	function automatic int slot_of_id(logic [31:0] id);
		for (int i = 0; i < DEPTH; i++)
			if (book_live[i] && book_id[i] == id) return i;
		return -1;
	endfunction

	function automatic int first_free_slot();
		for (int i = 0; i < DEPTH; i++)
			if (!book_live[i]) return i;
		return -1;
	endfunction

	function automatic int best_resting(logic taker_side, logic [15:0] limit);
		int best;
		logic better;
		best = -1;
		for (int i = 0; i < DEPTH; i++) begin
			if (!book_live[i] || book_side[i] == taker_side) continue;
			if (taker_side == SIDE_BUY ? (book_price[i] > limit) : (book_price[i] < limit))
				continue;
			if (best < 0) begin
				best = i;
				continue;
			end
			if (book_price[i] != book_price[best])
				better = (taker_side == SIDE_BUY) ? (book_price[i] < book_price[best])
					: (book_price[i] > book_price[best]);
			else
				better = book_id[i] < book_id[best];
			if (better) best = i;
		end
		return best;
	endfunction

	task automatic rest_order(int s, logic [31:0] id, logic sd, logic [15:0] p,
			logic [23:0] q);
		book_live[s]  = 1'b1;
		book_id[s]    = id;
		book_side[s]  = sd;
		book_price[s] = p;
		book_qty[s]   = q;
	endtask

	// Apply one order to the book and queue the trades and completion it yields.
	task automatic apply_order(logic [2:0] m, logic [31:0] id, logic sd, logic [15:0] p,
			logic [23:0] q, logic [47:0] ts);
		logic [1:0]  sts;
		logic [38:0] lots;
		logic [23:0] remaining;
		logic [23:0] fill;
		logic [15:0] bid;
		logic [15:0] ask;
		logic        have_ask;
		int          s;
		int          fills;
		result_t     rec;
		sts = STS_OK;
		lots = '0;
		fills = 0;
		case (m)
			MODE_ADD: begin
				if (p != 0 && q != 0) begin
					if (slot_of_id(id) >= 0) sts = STS_DUP;
					else begin
						s = first_free_slot();
						if (s < 0) sts = STS_FULL;
						else rest_order(s, id, sd, p, q);
					end
				end
			end
			MODE_CANCEL: begin
				s = slot_of_id(id);
				if (s < 0) sts = STS_NOTFOUND;
				else book_live[s] = 1'b0;
			end
			MODE_MATCH: begin
				if (p != 0) begin
					if (slot_of_id(id) >= 0) sts = STS_DUP;
					else begin
						remaining = q;
						while (remaining > 0 && fills < DEPTH) begin
							s = best_resting(sd, p);
							if (s < 0) break;
							fill = (remaining < book_qty[s]) ? remaining : book_qty[s];
							rec = '0;
							rec.kind           = KIND_TRADE;
							rec.maker_id       = book_id[s];
							rec.taker_id       = id;
							rec.trade_price    = book_price[s];
							rec.trade_qty      = fill;
							rec.trade_time     = ts;
							rec.aggressor_side = sd;
							expected_records.push_back(rec);
							fills++;
							remaining -= fill;
							book_qty[s] -= fill;
							if (book_qty[s] == 0) book_live[s] = 1'b0;
						end
						if (remaining > 0) begin
							s = first_free_slot();
							if (s < 0) sts = STS_FULL;
							else rest_order(s, id, sd, p, remaining);
						end
					end
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < DEPTH; i++) book_live[i] = 1'b0;
			end
			MODE_QUERY: begin
				for (int i = 0; i < DEPTH; i++)
					if (book_live[i] && book_side[i] == sd && book_price[i] == p)
						lots += 39'(book_qty[i]);
			end
			default: ;
		endcase
		bid = '0;
		ask = '0;
		have_ask = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (!book_live[i]) continue;
			if (book_side[i] == SIDE_BUY) begin
				if (book_price[i] > bid) bid = book_price[i];
			end else if (!have_ask || book_price[i] < ask) begin
				ask = book_price[i];
				have_ask = 1'b1;
			end
		end
		rec = '0;
		rec.kind           = KIND_DONE;
		rec.bid_px         = bid;
		rec.ask_px         = ask;
		rec.level_quantity = lots;
		rec.status         = sts;
		rec.last           = 1'b1;
		expected_records.push_back(rec);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			expected_records.delete();
			for (int i = 0; i < DEPTH; i++) book_live[i] = 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_records.size() == 0) begin
					$error("result item with no expected record waiting");
					errors++;
				end else begin
					want = expected_records.pop_front();
					check_field("kind", 64'(want.kind), 64'(kind));
					check_field("maker_id", 64'(want.maker_id), 64'(maker_id));
					check_field("taker_id", 64'(want.taker_id), 64'(taker_id));
					check_field("trade_price", 64'(want.trade_price), 64'(trade_price));
					check_field("trade_qty", 64'(want.trade_qty), 64'(trade_qty));
					check_field("trade_time", 64'(want.trade_time), 64'(trade_time));
					check_field("aggressor_side", 64'(want.aggressor_side),
						64'(aggressor_side));
					check_field("bid_px", 64'(want.bid_px), 64'(bid_px));
					check_field("ask_px", 64'(want.ask_px), 64'(ask_px));
					check_field("level_quantity", 64'(want.level_quantity),
						64'(level_quantity));
					check_field("status", 64'(want.status), 64'(status));
					check_field("last", 64'(want.last), 64'(last));
				end
			end
			if (push && !full)
				apply_order(mode, oid, side, price, quantity, timestamp);
		end
	end

endmodule

FILE: tb/sv/limit_order_book_matcher_unit_tb.sv
`timescale 1ns / 100ps

module limit_order_book_matcher_unit_tb import lobm_pkg::*;;

	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_ORDERS = 306;
	localparam int HOLD_START    = 2000;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_START   = 8000;
	localparam int QUIET_CYCLES  = 3000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  mode;
	logic [31:0] oid;
	logic        side;
	logic [15:0] price;
	logic [23:0] quantity;
	logic [47:0] timestamp;
	logic        empty;
	logic        pop;
	logic        kind;
	logic [31:0] maker_id;
	logic [31:0] taker_id;
	logic [15:0] trade_price;
	logic [23:0] trade_qty;
	logic [47:0] trade_time;
	logic        aggressor_side;
	logic [15:0] bid_px;
	logic [15:0] ask_px;
	logic [38:0] level_quantity;
	logic [1:0]  status;
	logic        last;
	int          errors;
	int          pending;
	int          idle_cycles;
	bit          sender_quiet;

	limit_order_book_matcher_unit uut (.*);

	limit_order_book_matcher_unit_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, one long hold-off to back the block up, one quiet stretch.
	initial begin
		int cyc;
		cyc = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
				pop <= 1'b0;
			else if (cyc >= QUIET_START && cyc < QUIET_START + QUIET_CYCLES)
				pop <= 1'b1;
			else
				pop <= ($urandom_range(99) >= 10);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic offer(logic [2:0] m, logic [31:0] id, logic sd, logic [15:0] p,
			logic [23:0] q, logic [47:0] ts);
		if (!sender_quiet && $urandom_range(99) < 10) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		mode      <= m;
		oid       <= id;
		side      <= sd;
		price     <= p;
		quantity  <= q;
		timestamp <= ts;
		push      <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	function automatic logic [47:0] any_time();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[47:0];
	endfunction

	initial begin
		logic [2:0]  m;
		logic [31:0] id;
		logic [15:0] p;
		logic [23:0] q;
		int          pick;
		arst_n = 1'b0;
		push = 1'b0;
		mode = MODE_ADD;
		oid = '0;
		side = SIDE_BUY;
		price = '0;
		quantity = '0;
		timestamp = '0;
		sender_quiet = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes and each special case.
		offer(MODE_ADD, '1, SIDE_BUY, '1, '1, '1);
		offer(MODE_ADD, '0, ~SIDE_BUY, 16'd1, 24'd1, '0);
		offer(MODE_ADD, 32'd9, SIDE_BUY, 16'd0, 24'd5, any_time());
		offer(MODE_ADD, 32'd9, SIDE_BUY, 16'd5, 24'd0, any_time());
		offer(MODE_ADD, '0, SIDE_BUY, 16'd7, 24'd3, any_time());
		offer(MODE_QUERY, '0, SIDE_BUY, '1, '0, '0);
		offer(MODE_QUERY, '0, ~SIDE_BUY, 16'd7, '0, '0);
		offer(MODE_CANCEL, 32'd12345, SIDE_BUY, '0, '0, '0);
		offer(MODE_CANCEL, '0, SIDE_BUY, '0, '0, '0);
		offer(MODE_MATCH, '1, ~SIDE_BUY, 16'd1, 24'd5, any_time());
		offer(MODE_MATCH, 32'd11, ~SIDE_BUY, 16'd0, 24'd5, any_time());
		offer(MODE_MATCH, 32'd12, ~SIDE_BUY, 16'd1, 24'd0, any_time());
		offer(MODE_MATCH, 32'd13, ~SIDE_BUY, 16'd1, 24'd5, '1);
		offer(MODE_MATCH, 32'd14, ~SIDE_BUY, 16'd1, '1, any_time());
		for (int i = MODE_QUERY + 1; i <= 7; i++)
			offer(3'(i), '1, ~SIDE_BUY, '1, '1, '1);
		offer(MODE_CLEAR, '0, SIDE_BUY, '0, '0, '0);
		// Fill the table, then reject, drop a remainder, and sweep every level.
		for (int i = 0; i < MAX_ORDERS_DEF; i++)
			offer(MODE_ADD, 32'(100 + i), ~SIDE_BUY, 16'(200 + i), 24'd10, any_time());
		offer(MODE_ADD, 32'd300, SIDE_BUY, 16'd50, 24'd4, any_time());
		offer(MODE_MATCH, 32'd301, SIDE_BUY, 16'd150, 24'd4, any_time());
		offer(MODE_MATCH, 32'd302, SIDE_BUY, '1, 24'd1000, any_time());
		offer(MODE_CLEAR, '0, SIDE_BUY, '0, '0, '0);

		for (int n = 0; n < RANDOM_ORDERS; n++) begin
			sender_quiet = (n >= 150 && n < 230);
			pick = $urandom_range(99);
			id = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(1, 60));
			p = ($urandom_range(19) == 0) ? 16'($urandom()) : 16'($urandom_range(90, 110));
			q = ($urandom_range(19) == 0) ? 24'($urandom()) : 24'($urandom_range(1, 50));
			if (pick < 35) m = MODE_ADD;
			else if (pick < 72) m = MODE_MATCH;
			else if (pick < 84) m = MODE_CANCEL;
			else if (pick < 94) m = MODE_QUERY;
			else if (pick < 96) m = MODE_CLEAR;
			else m = 3'($urandom_range(7, MODE_QUERY + 1));
			offer(m, id, 1'($urandom()), p, q, any_time());
		end
		push <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
